>>> rtl/core/tbp_pkg.sv
// ----------------------------------------------------------------------------
// Tournament branch predictor package
// Command codes, fixed field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tbp_pkg;

	localparam int ADDR_W   = 32;
	localparam int ADDR_LSB = 2;

	localparam logic CMD_PREDICT = 1'b0;
	localparam logic CMD_UPDATE  = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clr;      // write zero into every table at the sweep index
		logic rd_hist;  // item accepted: read local history, global and choice
		logic rd_ctr;   // read local counter at the fetched history
		logic eval;     // form verdicts; answer a predict or write back an update
	} tbp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clr_last; // sweep is at its final index
	} tbp_sts_t;

endpackage

>>> rtl/core/tbp_ctrl.sv
// ----------------------------------------------------------------------------
// Tournament branch predictor controller
// Sequences the table clearing sweep and the three steps of each item.
// ----------------------------------------------------------------------------
module tbp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tbp_pkg::tbp_sts_t sts,
	output tbp_pkg::tbp_cmd_t cmd,
	output logic              busy
);
	import tbp_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_HIST  = 2'd2;
	localparam logic [1:0] ST_EVAL  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.rd_hist = start;
				if (start) begin
					state_nxt = ST_HIST;
				end
			end
			ST_HIST: begin
				cmd.rd_ctr = 1'b1;
				state_nxt  = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval  = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> rtl/core/tbp_dp.sv
// ----------------------------------------------------------------------------
// Tournament branch predictor datapath
// Holds the four tables, the path history and the last prediction.
// ----------------------------------------------------------------------------
module tbp_dp #(
	parameter int LOCAL_ENTRIES_LOG2  = 10,
	parameter int LOCAL_HISTORY_BITS  = 10,
	parameter int GLOBAL_HISTORY_BITS = 12,
	parameter int LOCAL_COUNTER_BITS  = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tbp_pkg::tbp_cmd_t            cmd,
	output tbp_pkg::tbp_sts_t            sts,
	input  logic                         command,
	input  logic [tbp_pkg::ADDR_W-1:0]   instruction_address,
	input  logic                         cond_branch,
	input  logic                         taken,
	output logic                         prediction,
	output logic                         done
);
	import tbp_pkg::*;

	localparam int LE  = LOCAL_ENTRIES_LOG2;
	localparam int LH  = LOCAL_HISTORY_BITS;
	localparam int GH  = GLOBAL_HISTORY_BITS;
	localparam int LCB = LOCAL_COUNTER_BITS;
	localparam int CW0 = (LE > LH) ? LE : LH;
	localparam int CW  = (CW0 > GH) ? CW0 : GH;

	localparam logic [LCB-1:0] LC_ONE = {{(LCB-1){1'b0}}, 1'b1};
	localparam logic [LCB-1:0] LC_MAX = {LCB{1'b1}};

	logic [LH-1:0]  lh_mem [2**LE];
	logic [LCB-1:0] lc_mem [2**LH];
	logic [1:0]     gc_mem [2**GH];
	logic [1:0]     cc_mem [2**GH];

	logic [CW-1:0]  clr_cnt_q;
	logic [GH-1:0]  path_q;
	logic           last_q;
	logic           done_q;
	logic           pred_q;

	logic           cmd_q;
	logic           cond_q;
	logic           taken_q;
	logic [LE-1:0]  slot_q;

	logic [LH-1:0]  lh_rd_q;
	logic [LCB-1:0] lc_rd_q;
	logic [1:0]     gc_rd_q;
	logic [1:0]     cc_rd_q;

	logic [LE-1:0]  slot_in;
	logic           lv;
	logic           gv;
	logic           pred;
	logic           upd;
	logic [LCB-1:0] lc_new;
	logic [1:0]     gc_new;
	logic [1:0]     cc_new;

	assign slot_in = instruction_address[LE+ADDR_LSB-1:ADDR_LSB];

	assign sts.clr_last = (clr_cnt_q == {CW{1'b1}});

	// Verdicts and choice
	assign lv   = lc_rd_q[LCB-1];
	assign gv   = gc_rd_q[1];
	assign pred = (lv == gv) ? lv : (cc_rd_q[1] ? gv : lv);
	assign upd  = cmd.eval && (cmd_q == CMD_UPDATE);

	// Saturating training toward the outcome; choice toward the right verdict
	always_comb begin
		if (taken_q) begin
			lc_new = (lc_rd_q == LC_MAX) ? lc_rd_q : lc_rd_q + LC_ONE;
			gc_new = (gc_rd_q == 2'b11) ? gc_rd_q : gc_rd_q + 2'd1;
		end else begin
			lc_new = (lc_rd_q == '0) ? lc_rd_q : lc_rd_q - LC_ONE;
			gc_new = (gc_rd_q == 2'b00) ? gc_rd_q : gc_rd_q - 2'd1;
		end
		if (lv == taken_q) begin
			cc_new = (cc_rd_q == 2'b00) ? cc_rd_q : cc_rd_q - 2'd1;
		end else begin
			cc_new = (cc_rd_q == 2'b11) ? cc_rd_q : cc_rd_q + 2'd1;
		end
	end

	// Local history table
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			lh_mem[clr_cnt_q[LE-1:0]] <= '0;
		end else if (upd) begin
			lh_mem[slot_q] <= {lh_rd_q[LH-2:0], taken_q};
		end
		if (cmd.rd_hist) begin
			lh_rd_q <= lh_mem[slot_in];
		end
	end

	// Local counter table
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			lc_mem[clr_cnt_q[LH-1:0]] <= '0;
		end else if (upd) begin
			lc_mem[lh_rd_q] <= lc_new;
		end
		if (cmd.rd_ctr) begin
			lc_rd_q <= lc_mem[lh_rd_q];
		end
	end

	// Global counter table
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			gc_mem[clr_cnt_q[GH-1:0]] <= '0;
		end else if (upd) begin
			gc_mem[path_q] <= gc_new;
		end
		if (cmd.rd_hist) begin
			gc_rd_q <= gc_mem[path_q];
		end
	end

	// Choice counter table: trained only when the verdicts differ
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			cc_mem[clr_cnt_q[GH-1:0]] <= '0;
		end else if (upd && (lv != gv)) begin
			cc_mem[path_q] <= cc_new;
		end
		if (cmd.rd_hist) begin
			cc_rd_q <= cc_mem[path_q];
		end
	end

	// Item capture and result payload
	always_ff @(posedge clk) begin
		if (cmd.rd_hist) begin
			cmd_q   <= command;
			cond_q  <= cond_branch;
			taken_q <= taken;
			slot_q  <= slot_in;
		end
		if (cmd.eval) begin
			pred_q <= cond_q ? pred : last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			path_q    <= '0;
			last_q    <= 1'b1;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.eval && (cmd_q == CMD_PREDICT);
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + {{(CW-1){1'b0}}, 1'b1};
			end
			if (cmd.eval && (cmd_q == CMD_PREDICT) && cond_q) begin
				last_q <= pred;
			end
			if (upd) begin
				path_q <= {path_q[GH-2:0], taken_q};
			end
		end
	end

	assign prediction = pred_q;
	assign done       = done_q;

endmodule

>>> rtl/core/tournament_branch_predictor.sv
// ----------------------------------------------------------------------------
// Tournament branch predictor
// Local, global and choice predictors in single-port tables with a sequencer.
// ----------------------------------------------------------------------------
// After reset the block sweeps its tables to zero over 2**max(
// LOCAL_ENTRIES_LOG2, LOCAL_HISTORY_BITS, GLOBAL_HISTORY_BITS) indices (4096
// by default) and holds busy high meanwhile. Each item then runs through three
// steps: one to read the local history, global and choice counters, one to
// read the local counter that the history selects, and one to form the
// verdicts and either answer or write the tables back. A predict item drives
// its prediction from the edge ending the last step, with done high for exactly
// one cycle, so it is taken at the edge that closes that cycle; the receiver
// cannot stall, so sample it then. Update items raise no done but reload the
// prediction output. A new item may be started in the cycle done is shown.
module tournament_branch_predictor #(
	parameter int LOCAL_ENTRIES_LOG2  = 10,
	parameter int LOCAL_HISTORY_BITS  = 10,
	parameter int GLOBAL_HISTORY_BITS = 12,
	parameter int LOCAL_COUNTER_BITS  = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       command,
	input  logic [tbp_pkg::ADDR_W-1:0] instruction_address,
	input  logic                       cond_branch,
	input  logic                       taken,
	output logic                       prediction,
	output logic                       done
);
	import tbp_pkg::*;

	tbp_cmd_t cmd;
	tbp_sts_t sts;

	// Sequence the clearing sweep and the per-item steps
	tbp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Hold the tables and histories; answer predicts, train on updates
	tbp_dp #(
		.LOCAL_ENTRIES_LOG2  (LOCAL_ENTRIES_LOG2),
		.LOCAL_HISTORY_BITS  (LOCAL_HISTORY_BITS),
		.GLOBAL_HISTORY_BITS (GLOBAL_HISTORY_BITS),
		.LOCAL_COUNTER_BITS  (LOCAL_COUNTER_BITS)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.command             (command),
		.instruction_address (instruction_address),
		.cond_branch         (cond_branch),
		.taken               (taken),
		.prediction          (prediction),
		.done                (done)
	);

	// An accepted item keeps the block busy for the following cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepting an item");

	// A result is shown only as the item finishes, for one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// A result follows a cycle in which the block was working
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("done without a preceding evaluation step");

	// The clearing sweep never runs together with item steps
	a_clr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> (!cmd.rd_hist && !cmd.rd_ctr && !cmd.eval))
		else $error("clearing sweep overlaps an item");

endmodule
